/* sv/fpa_pkg.sv */
package fpa_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int DATA_W        = 32;
  localparam int Q_DEPTH       = 4;

  localparam logic [3:0] FN_ADD      = 4'd0;
  localparam logic [3:0] FN_SUB      = 4'd1;
  localparam logic [3:0] FN_MUL      = 4'd2;
  localparam logic [3:0] FN_DIV      = 4'd3;
  localparam logic [3:0] FN_GT       = 4'd4;
  localparam logic [3:0] FN_LT       = 4'd5;
  localparam logic [3:0] FN_GE       = 4'd6;
  localparam logic [3:0] FN_LE       = 4'd7;
  localparam logic [3:0] FN_EQ       = 4'd8;
  localparam logic [3:0] FN_NE       = 4'd9;
  localparam logic [3:0] FN_MIN      = 4'd10;
  localparam logic [3:0] FN_MAX      = 4'd11;
  localparam logic [3:0] FN_INC      = 4'd12;
  localparam logic [3:0] FN_DEC      = 4'd13;
  localparam logic [3:0] FN_TO_INT   = 4'd14;
  localparam logic [3:0] FN_FROM_INT = 4'd15;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_SAT  = 2'd1;
  localparam logic [1:0] ST_DIVZ = 2'd2;

  localparam logic [1:0] K_SIMPLE = 2'd0;
  localparam logic [1:0] K_MUL    = 2'd1;
  localparam logic [1:0] K_DIV    = 2'd2;
  localparam logic [1:0] K_DIVZ   = 2'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic        neg;
    logic [3:0]  func;
    logic [31:0] a;
    logic [31:0] b;
  } cmd_t;

  typedef struct packed {
    logic [31:0] result;
    logic        flag;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } sat_t;

  function automatic sat_t clamp_mag(input logic [63:0] mag, input logic neg);
    sat_t r;
    r.sat   = 1'b0;
    r.value = mag[31:0];
    if (neg) begin
      if (mag > 64'h8000_0000) begin
        r.value = 32'h8000_0000;
        r.sat   = 1'b1;
      end else begin
        r.value = ~mag[31:0] + 32'd1;
      end
    end else if (mag > 64'h7FFF_FFFF) begin
      r.value = 32'h7FFF_FFFF;
      r.sat   = 1'b1;
    end
    return r;
  endfunction

endpackage

/* sv/fpa_queue.sv */
module fpa_queue #(
  parameter int W     = 8,
  parameter int DEPTH = fpa_pkg::Q_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [W-1:0] wr_data,
  input  logic         rd_en,
  output logic [W-1:0] rd_data,
  output logic         full,
  output logic         empty
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic do_wr, do_rd;

  assign full    = (cnt_r == (AW+1)'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = mem[rp_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem[wp_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_wr) wp_r <= wp_r + AW'(1);
      if (do_rd) rp_r <= rp_r + AW'(1);
      if (do_wr && !do_rd) cnt_r <= cnt_r + (AW+1)'(1);
      else if (do_rd && !do_wr) cnt_r <= cnt_r - (AW+1)'(1);
    end
  end
endmodule

/* sv/fpa_front.sv */
module fpa_front (
  input  logic               push,
  input  logic [3:0]         func,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  input  logic               cmd_full,
  output logic               full,
  output logic               cmd_wr,
  output fpa_pkg::cmd_t      cmd
);
  assign full   = cmd_full;
  assign cmd_wr = push && !cmd_full;

  always_comb begin
    cmd.func = func;
    cmd.a    = operand_a;
    cmd.b    = operand_b;
    cmd.neg  = operand_a[31] ^ operand_b[31];
    case (func)
      fpa_pkg::FN_MUL: cmd.kind = fpa_pkg::K_MUL;
      fpa_pkg::FN_DIV: cmd.kind = (operand_b == '0) ? fpa_pkg::K_DIVZ : fpa_pkg::K_DIV;
      default:         cmd.kind = fpa_pkg::K_SIMPLE;
    endcase
  end
endmodule

/* sv/fpa_back.sv */
module fpa_back #(
  parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  fpa_pkg::cmd_t cmd,
  input  logic          cmd_empty,
  output logic          cmd_rd,
  input  logic          rsp_full,
  output logic          rsp_wr,
  output fpa_pkg::rsp_t rsp
);
  localparam int NB   = 32 + FRACTION_BITS;
  localparam int CNTW = $clog2(NB + 1);
  localparam logic [1:0] S_RUN  = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_DFIN = 2'd3;
  localparam logic signed [33:0] MAX34 = 34'sd2147483647;
  localparam logic signed [33:0] MIN34 = -34'sd2147483648;
  localparam logic signed [63:0] MAX64 = 64'sd2147483647;
  localparam logic signed [63:0] MIN64 = -64'sd2147483648;

  logic [1:0]      state_r;
  logic [63:0]     prod_r;
  logic            neg_r;
  logic [NB-1:0]   num_r;
  logic [32:0]     rem_r;
  logic [31:0]     den_r;
  logic [CNTW-1:0] cnt_r;

  logic [31:0] mag_a, mag_b;
  logic signed [33:0] a34, b34, w34;
  logic signed [63:0] w64;
  logic lt, eq;
  fpa_pkg::rsp_t simple_rsp;
  logic [32:0] rem_sh;
  logic        q_bit;
  logic        rnd;
  logic [63:0] mul_q, div_q;
  fpa_pkg::sat_t mul_c, div_c;
  logic take;

  assign mag_a = cmd.a[31] ? (~cmd.a + 32'd1) : cmd.a;
  assign mag_b = cmd.b[31] ? (~cmd.b + 32'd1) : cmd.b;
  assign a34   = {{2{cmd.a[31]}}, cmd.a};
  assign b34   = {{2{cmd.b[31]}}, cmd.b};
  assign lt    = $signed(cmd.a) < $signed(cmd.b);
  assign eq    = cmd.a == cmd.b;
  assign w64   = $signed({{32{cmd.a[31]}}, cmd.a}) <<< FRACTION_BITS;

  always_comb begin
    simple_rsp.result = '0;
    simple_rsp.flag   = 1'b0;
    simple_rsp.status = fpa_pkg::ST_OK;
    w34 = '0;
    case (cmd.func)
      fpa_pkg::FN_ADD: w34 = a34 + b34;
      fpa_pkg::FN_SUB: w34 = a34 - b34;
      fpa_pkg::FN_INC: w34 = a34 + 34'sd1;
      fpa_pkg::FN_DEC: w34 = a34 - 34'sd1;
      default:         w34 = '0;
    endcase
    case (cmd.func)
      fpa_pkg::FN_ADD, fpa_pkg::FN_SUB, fpa_pkg::FN_INC, fpa_pkg::FN_DEC: begin
        if (w34 > MAX34) begin
          simple_rsp.result = 32'h7FFF_FFFF;
          simple_rsp.status = fpa_pkg::ST_SAT;
        end else if (w34 < MIN34) begin
          simple_rsp.result = 32'h8000_0000;
          simple_rsp.status = fpa_pkg::ST_SAT;
        end else begin
          simple_rsp.result = w34[31:0];
        end
      end
      fpa_pkg::FN_GT:  simple_rsp.flag = !lt && !eq;
      fpa_pkg::FN_LT:  simple_rsp.flag = lt;
      fpa_pkg::FN_GE:  simple_rsp.flag = !lt;
      fpa_pkg::FN_LE:  simple_rsp.flag = lt || eq;
      fpa_pkg::FN_EQ:  simple_rsp.flag = eq;
      fpa_pkg::FN_NE:  simple_rsp.flag = !eq;
      fpa_pkg::FN_MIN: simple_rsp.result = lt ? cmd.a : cmd.b;
      fpa_pkg::FN_MAX: simple_rsp.result = lt ? cmd.b : cmd.a;
      fpa_pkg::FN_TO_INT: simple_rsp.result = $signed(cmd.a) >>> FRACTION_BITS;
      fpa_pkg::FN_FROM_INT: begin
        if (w64 > MAX64) begin
          simple_rsp.result = 32'h7FFF_FFFF;
          simple_rsp.status = fpa_pkg::ST_SAT;
        end else if (w64 < MIN64) begin
          simple_rsp.result = 32'h8000_0000;
          simple_rsp.status = fpa_pkg::ST_SAT;
        end else begin
          simple_rsp.result = w64[31:0];
        end
      end
      fpa_pkg::FN_DIV: begin
        simple_rsp.status = fpa_pkg::ST_DIVZ;
        if (cmd.a[31]) simple_rsp.result = 32'h8000_0000;
        else if (cmd.a != '0) simple_rsp.result = 32'h7FFF_FFFF;
        else simple_rsp.result = '0;
      end
      default: simple_rsp.result = '0;
    endcase
  end

  assign rem_sh = {rem_r[31:0], num_r[NB-1]};
  assign q_bit  = rem_sh >= {1'b0, den_r};
  assign rnd    = {rem_r, 1'b0} >= {2'b00, den_r};
  assign mul_q  = (prod_r + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
  assign div_q  = 64'(num_r) + 64'(rnd);
  assign mul_c  = fpa_pkg::clamp_mag(mul_q, neg_r);
  assign div_c  = fpa_pkg::clamp_mag(div_q, neg_r);

  assign take   = (state_r == S_RUN) && !cmd_empty && !rsp_full;
  assign cmd_rd = take;

  always_comb begin
    rsp_wr = 1'b0;
    rsp    = simple_rsp;
    case (state_r)
      S_RUN: rsp_wr = take && (cmd.kind == fpa_pkg::K_SIMPLE || cmd.kind == fpa_pkg::K_DIVZ);
      S_MUL: begin
        rsp_wr     = !rsp_full;
        rsp.result = mul_c.value;
        rsp.flag   = 1'b0;
        rsp.status = mul_c.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
      end
      S_DFIN: begin
        rsp_wr     = !rsp_full;
        rsp.result = div_c.value;
        rsp.flag   = 1'b0;
        rsp.status = div_c.sat ? fpa_pkg::ST_SAT : fpa_pkg::ST_OK;
      end
      default: rsp_wr = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (take) begin
      prod_r <= 64'(mag_a) * 64'(mag_b);
      neg_r  <= cmd.neg;
      den_r  <= mag_b;
      num_r  <= {mag_a, {FRACTION_BITS{1'b0}}};
      rem_r  <= '0;
      cnt_r  <= CNTW'(NB);
    end else if (state_r == S_DIV) begin
      rem_r <= q_bit ? (rem_sh - {1'b0, den_r}) : rem_sh;
      num_r <= {num_r[NB-2:0], q_bit};
      cnt_r <= cnt_r - CNTW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_RUN;
    end else begin
      case (state_r)
        S_RUN: begin
          if (take && cmd.kind == fpa_pkg::K_MUL) state_r <= S_MUL;
          else if (take && cmd.kind == fpa_pkg::K_DIV) state_r <= S_DIV;
        end
        S_MUL:  if (!rsp_full) state_r <= S_RUN;
        S_DIV:  if (cnt_r == CNTW'(1)) state_r <= S_DFIN;
        S_DFIN: if (!rsp_full) state_r <= S_RUN;
        default: state_r <= S_RUN;
      endcase
    end
  end
endmodule

/* sv/fixed_point_q24_8_alu_unit.sv */
// Channel   Ports                                          Handshake
// input     in_func, in_operand_a, in_operand_b            push / full
// result    out_result, out_flag, out_status               empty / pop
//
// One request per cycle for all operations except mul and div, while the
// result queue has room. Mul and div hold the execute side busy until their
// result is written; div runs in the bit-serial restoring divider.
// Synchronous active-low reset empties both queues.
// Either side may stall; the command and result queues decouple them.
module fixed_point_q24_8_alu_unit #(
  parameter int FRACTION_BITS = fpa_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_operand_a,
  input  logic signed [31:0] in_operand_b,
  output logic               empty,
  input  logic               pop,
  output logic signed [31:0] out_result,
  output logic               out_flag,
  output logic [1:0]         out_status
);
  localparam int CW = $bits(fpa_pkg::cmd_t);
  localparam int RW = $bits(fpa_pkg::rsp_t);

  fpa_pkg::cmd_t cmd_in, cmd_out;
  fpa_pkg::rsp_t rsp_in, rsp_out;
  logic [CW-1:0] cmd_vec;
  logic [RW-1:0] rsp_vec;
  logic cmd_wr, cmd_rd, cmd_full, cmd_empty;
  logic rsp_wr, rsp_full;

  fpa_front u_front (
    .push      (push),
    .func      (in_func),
    .operand_a (in_operand_a),
    .operand_b (in_operand_b),
    .cmd_full  (cmd_full),
    .full      (full),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd_in)
  );

  fpa_queue #(.W(CW), .DEPTH(fpa_pkg::Q_DEPTH)) u_cmd_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .rd_en   (cmd_rd),
    .rd_data (cmd_vec),
    .full    (cmd_full),
    .empty   (cmd_empty)
  );

  assign cmd_out = fpa_pkg::cmd_t'(cmd_vec);

  fpa_back #(.FRACTION_BITS(FRACTION_BITS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd_out),
    .cmd_empty (cmd_empty),
    .cmd_rd    (cmd_rd),
    .rsp_full  (rsp_full),
    .rsp_wr    (rsp_wr),
    .rsp       (rsp_in)
  );

  fpa_queue #(.W(RW), .DEPTH(fpa_pkg::Q_DEPTH)) u_rsp_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (rsp_wr),
    .wr_data (rsp_in),
    .rd_en   (pop),
    .rd_data (rsp_vec),
    .full    (rsp_full),
    .empty   (empty)
  );

  assign rsp_out    = fpa_pkg::rsp_t'(rsp_vec);
  assign out_result = rsp_out.result;
  assign out_flag   = rsp_out.flag;
  assign out_status = rsp_out.status;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result queue not empty after reset");

  a_flag_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_flag) |-> (out_result == '0 && out_status == fpa_pkg::ST_OK))
    else $error("comparison result carries data or status");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_status == fpa_pkg::ST_OK || out_status == fpa_pkg::ST_SAT ||
                out_status == fpa_pkg::ST_DIVZ))
    else $error("undefined status code");

  a_divz_value: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && out_status == fpa_pkg::ST_DIVZ) |->
      (out_result == 32'h7FFF_FFFF || out_result == 32'h8000_0000 || out_result == '0))
    else $error("divide-by-zero result not saturated");
endmodule
